[hdl/hlam_pkg.sv]
// Shared types, constants and helper functions of the hybrid log approximate multiplier.
`default_nettype none

package hlam_pkg;

	// Operand width used when the top level is not given one
	localparam int OPERAND_W_DEF = 16;
	// Product width: every sum wraps at this width
	localparam int PROD_W = 32;
	// Signed low digit width; the digit stays within plus or minus 2^14
	localparam int DIGIT_W = 16;
	// Configuration register width
	localparam int CFG_W = 4;
	// Configuration index width
	localparam int CFG_IDX_W = 2;
	// Width of a leading-one position inside a product-wide word
	localparam int POS_W = 5;

	// Configuration reset values
	localparam logic [CFG_W-1:0] SPLIT_RST   = 4'd10;
	localparam logic [CFG_W-1:0] QUANT_X_RST = 4'd7;
	localparam logic [CFG_W-1:0] QUANT_Y_RST = 4'd8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPLIT   = 2'd0,
		CFG_QUANT_X = 2'd1,
		CFG_QUANT_Y = 2'd2
	} cfg_idx_t;

	// Multiplicand split into exact high part and signed low digit
	typedef struct packed {
		logic signed [DIGIT_W-1:0] x0;
		logic [PROD_W-1:0]         x1;
	} recode_t;

	// Position of the highest set bit; zero when no bit is set
	function automatic logic [POS_W-1:0] lead_pos(input logic [PROD_W-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < PROD_W; i++) begin
			if (v[i]) begin
				p = POS_W'(i);
			end
		end
		return p;
	endfunction

endpackage : hlam_pkg

`default_nettype wire

[hdl/hybrid_log_approx_multiplier.sv]
// The item valid bit passes through valid_s1, valid_s2 and valid_s3 into the result strobe done.
// Throughput: one item per cycle; busy stays low, the four register stages never stall.
// Depth per stage is set by the 32x32 high-part multiplier and the two leading-one encoders.
// Reset: arst_n clears the stage valid bits and loads split 10, quant_x 7, quant_y 8.
// Configuration must be written only while no item is in flight.
`default_nettype none

module hybrid_log_approx_multiplier
	import hlam_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_W_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [OPERAND_WIDTH-1:0] multiplicand,
	input  wire logic signed [OPERAND_WIDTH-1:0] multiplier,
	output logic                                 done,
	output logic signed [PROD_W-1:0]             product,
	input  wire logic                            cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]            cfg_index,
	input  wire logic [CFG_W-1:0]                cfg_data
);

	logic [CFG_W-1:0] split_q;
	logic [CFG_W-1:0] quant_x_q;
	logic [CFG_W-1:0] quant_y_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q   <= SPLIT_RST;
			quant_x_q <= QUANT_X_RST;
			quant_y_q <= QUANT_Y_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SPLIT:   split_q   <= cfg_data;
				CFG_QUANT_X: quant_x_q <= cfg_data;
				CFG_QUANT_Y: quant_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: split the multiplicand, flag a zero operand
	recode_t rec_c;

	hlam_recode #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_recode (
		.x    (multiplicand),
		.split(split_q),
		.rec  (rec_c)
	);

	logic                            valid_s1;
	recode_t                         rec_s1;
	logic signed [OPERAND_WIDTH-1:0] y_s1;
	logic                            zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		rec_s1  <= rec_c;
		y_s1    <= multiplier;
		zero_s1 <= (multiplicand == '0) || (multiplier == '0);
	end

	// Stage 2: exact high product, magnitudes and leading-one positions
	logic [PROD_W-1:0]  y32;
	logic [PROD_W-1:0]  ya;
	logic [DIGIT_W-1:0] xa;
	logic               sx;
	logic               sy;
	logic               neg;
	logic [POS_W-1:0]   k1t;
	logic [POS_W-1:0]   k1;
	logic [POS_W-1:0]   k2t;
	logic [PROD_W-1:0]  x00;

	assign y32 = PROD_W'(y_s1);
	assign sy  = y_s1[OPERAND_WIDTH-1];
	assign sx  = rec_s1.x0[DIGIT_W-1];
	assign neg = sx ^ sy;
	assign xa  = sx ? ~rec_s1.x0 : rec_s1.x0;
	assign ya  = sy ? ~y32 : y32;
	assign k1t = lead_pos(PROD_W'(xa));
	assign k2t = lead_pos(ya);
	assign k1  = (k1t >= POS_W'(quant_x_q)) ? k1t : '0;
	assign x00 = PROD_W'(xa) - (PROD_W'(1) << k1);

	logic              valid_s2;
	logic [PROD_W-1:0] mult_s2;
	logic [PROD_W-1:0] xterm_s2;
	logic [PROD_W-1:0] yterm_s2;
	logic [POS_W-1:0]  k1_s2;
	logic [POS_W-1:0]  k2_s2;
	logic              b_en_s2;
	logic              lower_en_s2;
	logic              zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mult_s2     <= y32 * rec_s1.x1;
		xterm_s2    <= neg ? ~x00 : x00;
		yterm_s2    <= neg ? ~ya : ya;
		k1_s2       <= k1;
		k2_s2       <= k2t;
		b_en_s2     <= (k2t >= POS_W'(quant_y_q)) && (xa != '0);
		lower_en_s2 <= (rec_s1.x0 != '0);
		zero_s2     <= zero_s1;
	end

	// Stage 3: shift the exact part, form the logarithmic partial product
	logic [PROD_W-1:0] b_term;
	logic [PROD_W-1:0] a_term;

	// The correction weight and its shift by quant_y combine into one shift by k2
	assign b_term = b_en_s2 ? (xterm_s2 << k2_s2) : '0;
	assign a_term = yterm_s2 << k1_s2;

	logic              valid_s3;
	logic [PROD_W-1:0] exact_s3;
	logic [PROD_W-1:0] lower_s3;
	logic              zero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		exact_s3 <= mult_s2 << split_q;
		lower_s3 <= lower_en_s2 ? (b_term + a_term) : '0;
		zero_s3  <= zero_s2;
	end

	// Stage 4: final sum, drop everything on a zero operand
	logic              done_s4;
	logic [PROD_W-1:0] product_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		product_s4 <= zero_s3 ? '0 : (exact_s3 + lower_s3);
	end

	assign done    = done_s4;
	assign product = product_s4;

`ifndef SYNTHESIS
	// Every item taken comes out as a result strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("item lost in pipeline");

	// A result strobe only follows an item that was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without item");

	// A zero operand yields a zero product
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && (multiplicand == '0 || multiplier == '0)) |-> ##4 (product == '0))
		else $error("zero operand gave non-zero product");

	// A zero low digit contributes no partial product
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !lower_en_s2) |=> (lower_s3 == '0))
		else $error("partial product on zero digit");
`endif

endmodule : hybrid_log_approx_multiplier

`default_nettype wire

[hdl/hlam_recode.sv]
// Splits the multiplicand into an exact high part and a signed low digit.
`default_nettype none

module hlam_recode
	import hlam_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_W_DEF
) (
	input  wire logic signed [OPERAND_WIDTH-1:0] x,
	input  wire logic [CFG_W-1:0]                split,
	output recode_t                              rec
);

	// Wide enough to hold the split weight and the sign-extended operand
	localparam int XW = ((OPERAND_WIDTH > DIGIT_W) ? OPERAND_WIDTH : DIGIT_W) + 1;

	logic signed [XW-1:0] xe;
	logic signed [XW-1:0] xsh;
	logic signed [XW-1:0] x1f;
	logic [XW-1:0]        sd;
	logic [XW-1:0]        half;
	logic [XW-1:0]        u;
	logic [XW-1:0]        x0f;
	logic                 nonneg;
	logic                 adjust;

	// Take low bits and floor high part
	assign xe     = XW'(x);
	assign xsh    = xe >>> split;
	assign sd     = XW'(1) << split;
	assign half   = sd >> 1;
	assign u      = xe & (sd - XW'(1));
	assign nonneg = ~xe[XW-1];

	// Fold the digit into the symmetric range; a tie goes with the operand's sign
	assign adjust = (u != '0) && (nonneg ? (u > half) : (u >= half));
	assign x0f    = adjust ? (u - sd) : u;
	assign x1f    = xsh + XW'(adjust);

	assign rec.x0 = DIGIT_W'(x0f);
	assign rec.x1 = PROD_W'(x1f);

endmodule : hlam_recode

`default_nettype wire
